// ----- hdl/tdp_pkg.sv -----
`default_nettype none
package tdp_pkg;

  // Operand width; bit DATA_WIDTH-1 is the sign
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int SQ_W       = DATA_WIDTH + 1;

  typedef logic signed [DATA_WIDTH-1:0] value_t;
  typedef logic [DATA_WIDTH-1:0]        word_t;
  typedef logic [SQ_W-1:0]              square_t;

  // First odd trial divisor and its square
  localparam word_t   FIRST_DIV = word_t'(3);
  localparam square_t FIRST_SQ  = square_t'(9);
  localparam word_t   ONE_W     = word_t'(1);
  localparam word_t   TWO_W     = word_t'(2);
  localparam square_t FOUR_SQ   = square_t'(4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_DONE
  } tdp_state_t;

  // Request to the serial remainder unit
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } tdp_div_req_t;

  // Response from the serial remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdp_div_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/tdp_ifs.sv -----
`default_nettype none
// Operand channel
interface tdp_query_if;
  logic              valid;
  logic              ready;
  tdp_pkg::value_t   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Verdict channel
interface tdp_reply_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

// ----- hdl/trial_division_prime_test_top.sv -----
`default_nettype none
// Trial-division primality tester.
// query (sink): one signed DATA_WIDTH-bit value per transaction.
// reply (source): one is_prime bit per query, in order.
// Negative values, 0 and 1 are not prime, 2 is prime, other even values
// are not prime. Odd values are tried against divisors 3, 5, 7, ... while
// the divisor squared does not exceed the value; the square is kept
// incrementally, the remainder comes from a bit-serial divider.
// Trivial cases pass from accept through ST_DONE into the reply register.
// Each trial divisor costs one bound check plus a pass of the serial
// divider, one dividend bit per cycle, and its done strobe. One value is
// worked on at a time; the next query can be taken in the cycle after the
// verdict enters the output register.
// The verdict sits in an output register, so the next query is taken while
// a reply waits; if reply stalls, the following verdict waits until the
// register frees, and query stays not ready meanwhile.
// Reset (synchronous, active high) drops all work and any pending reply.
module trial_division_prime_test_top (
  input wire logic    clk,
  input wire logic    rst,
  tdp_query_if.sink   query,
  tdp_reply_if.source reply
);
  import tdp_pkg::*;

  tdp_state_t   state;
  tdp_state_t   state_next;
  word_t        n;
  word_t        d;
  square_t      sq;
  logic         verdict;
  logic         out_valid;
  logic         out_prime;

  tdp_div_req_t div_req;
  tdp_div_rsp_t div_rsp;

  // Classification of the incoming value
  word_t raw;
  logic  is_neg;
  logic  is_two;
  logic  is_trivial;
  logic  bound_hit;

  // Control strobes
  logic take;
  logic start_div;
  logic found_prime;
  logic found_comp;
  logic step_d;
  logic push_out;

  always_comb begin
    raw        = word_t'(query.value);
    is_neg     = raw[DATA_WIDTH-1];
    is_two     = (raw == TWO_W);
    is_trivial = is_neg || (raw <= ONE_W) || !raw[0];
    bound_hit  = (sq > {1'b0, n});
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query.valid) begin
          state_next = is_trivial ? ST_DONE : ST_TEST;
        end
      end
      ST_TEST: begin
        state_next = bound_hit ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = div_rsp.rem_zero ? ST_DONE : ST_TEST;
        end
      end
      ST_DONE: begin
        if (!out_valid || reply.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    query.ready = 1'b0;
    take        = 1'b0;
    start_div   = 1'b0;
    found_prime = 1'b0;
    found_comp  = 1'b0;
    step_d      = 1'b0;
    push_out    = 1'b0;
    case (state)
      ST_IDLE: begin
        query.ready = 1'b1;
        take        = query.valid;
      end
      ST_TEST: begin
        found_prime = bound_hit;
        start_div   = !bound_hit;
      end
      ST_DIV: begin
        found_comp = div_rsp.done && div_rsp.rem_zero;
        step_d     = div_rsp.done && !div_rsp.rem_zero;
      end
      ST_DONE: begin
        push_out = !out_valid || reply.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand, trial divisor and its running square
  always_ff @(posedge clk) begin
    if (take) begin
      n       <= raw;
      d       <= FIRST_DIV;
      sq      <= FIRST_SQ;
      verdict <= is_two;
    end else begin
      if (step_d) begin
        d  <= d + TWO_W;
        sq <= sq + ({1'b0, d} << 2) + FOUR_SQ;
      end
      if (found_prime) begin
        verdict <= 1'b1;
      end else if (found_comp) begin
        verdict <= 1'b0;
      end
    end
  end

  assign div_req.start    = start_div;
  assign div_req.dividend = n;
  assign div_req.divisor  = d;

  tdp_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_out) begin
      out_valid <= 1'b1;
    end else if (reply.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      out_prime <= verdict;
    end
  end

  assign reply.valid    = out_valid;
  assign reply.is_prime = out_prime;

endmodule
`default_nettype wire

// ----- hdl/tdp_divider.sv -----
`default_nettype none
// Bit-serial restoring remainder unit: one dividend bit per cycle
module tdp_divider (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tdp_pkg::tdp_div_req_t req,
  output tdp_pkg::tdp_div_rsp_t      rsp
);
  import tdp_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  word_t            num_sr;
  word_t            den;
  word_t            rem;

  logic [DATA_WIDTH:0] rem_sh;
  logic [DATA_WIDTH:0] diff;
  logic                ge;
  word_t               rem_next;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem, num_sr[DATA_WIDTH-1]};
    diff     = rem_sh - {1'b0, den};
    ge       = (rem_sh >= {1'b0, den});
    rem_next = ge ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_WIDTH - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sr <= req.dividend;
      den    <= req.divisor;
      rem    <= '0;
    end else if (busy) begin
      num_sr <= {num_sr[DATA_WIDTH-2:0], 1'b0};
      rem    <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.rem_zero = (rem == '0);

endmodule
`default_nettype wire

// ----- hdl/tdp_checker.sv -----
`default_nettype none
module tdp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_valid,
  input wire logic q_ready,
  input wire logic r_valid,
  input wire logic r_ready,
  input wire logic r_prime
);

  logic [1:0] pending;

  // Queries accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, q_valid && q_ready} - {1'b0, r_valid && r_ready};
    end
  end

  // One query in flight plus one held reply at most
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two queries outstanding");

  // Never a reply without a query behind it
  a_reply_backed: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> pending != 2'd0)
    else $error("reply without a pending query");

  // One value at a time: not ready right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !q_ready)
    else $error("query taken while another is in work");

  // Reply holds until taken
  a_reply_holds: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_prime))
    else $error("stalled reply changed");

endmodule

bind trial_division_prime_test_top tdp_checker u_tdp_checker (
  .clk     (clk),
  .rst     (rst),
  .q_valid (query.valid),
  .q_ready (query.ready),
  .r_valid (reply.valid),
  .r_ready (reply.ready),
  .r_prime (reply.is_prime)
);
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import tdp_pkg::*;

  // One pending verdict: the operand and its expected primality
  typedef struct {
    value_t value;
    bit     prime;
  } verdict_t;

  // Scoreboard: predicts each accepted operand, checks replies in order
  class prime_scoreboard;
    verdict_t expected_verdicts[$];
    int       mismatches;
    int       replies_checked;
    int       primes_seen;

    // Trial division on the operand seen as a DATA_WIDTH-bit two's complement value
    function bit trial_divide(value_t v);
      longint unsigned n;
      longint unsigned d;
      if (v[DATA_WIDTH-1]) return 1'b0;
      n = longint'(word_t'(v));
      if (n <= 1) return 1'b0;
      if (n == 2) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d * d <= n; d += 2) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_query(value_t v);
      verdict_t entry;
      entry.value = v;
      entry.prime = trial_divide(v);
      expected_verdicts.push_back(entry);
    endfunction

    function void check_reply(bit got);
      verdict_t entry;
      replies_checked++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected reply is_prime=%0b with no query pending", $realtime, got);
        return;
      end
      entry = expected_verdicts.pop_front();
      if (entry.prime) primes_seen++;
      if (got !== entry.prime) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] value %0d: is_prime expected %0b, got %0b",
                   $realtime, entry.value, entry.prime, got);
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  localparam int STALL_LIMIT   = 4_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 70;
  localparam int QUIET_ITEMS   = 15;
  localparam int TAIL_CYCLES   = 20;
  localparam longint MAX_POS   = 64'd2147483647;

  logic clk;
  logic rst;

  tdp_query_if query_ch ();
  tdp_reply_if reply_ch ();

  trial_division_prime_test_top dut (
    .clk   (clk),
    .rst   (rst),
    .query (query_ch.sink),
    .reply (reply_ch.source)
  );

  prime_scoreboard verdicts = new();

  bit quiet_phase;
  bit hold_reply;
  int queries_sent;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and known input levels from time zero
  initial begin
    rst            = 1'b1;
    query_ch.valid = 1'b0;
    query_ch.value = '0;
    reply_ch.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
  end

  // Monitors: note accepted queries, check accepted replies
  always @(posedge clk) begin
    if (!rst && query_ch.valid && query_ch.ready)
      verdicts.note_query(query_ch.value);
    if (!rst && reply_ch.valid && reply_ch.ready)
      verdicts.check_reply(reply_ch.is_prime);
  end

  // Reply side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_reply) begin
        reply_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_reply = 1'b0;
      end else if (!quiet_phase && !rst && $urandom_range(0, 3) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        reply_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no transaction happens for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((query_ch.valid && query_ch.ready) || (reply_ch.valid && reply_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("trial_division_prime_test_top test failed");
    $finish;
  end

  // Offer one operand and hold it until the transaction completes
  task automatic send_value(value_t v);
    @(negedge clk);
    query_ch.valid <= 1'b1;
    query_ch.value <= v;
    do @(posedge clk); while (!query_ch.ready);
    queries_sent++;
  endtask

  task automatic idle_query(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      query_ch.valid <= 1'b0;
    end
  endtask

  // Random gap between operands unless the run is in its quiet tail
  task automatic maybe_gap();
    if (!quiet_phase && $urandom_range(0, 3) == 0)
      idle_query($urandom_range(1, 7));
  endtask

  task automatic wait_drained();
    while (verdicts.pending() != 0) @(posedge clk);
  endtask

  // Mostly cheap operands; large ones are negative, even, or carry a small factor
  function automatic value_t random_value();
    int unsigned pick;
    longint      p;
    longint      q;
    pick = $urandom_range(0, 99);
    if (pick < 40) return value_t'($urandom_range(0, 4095));
    if (pick < 55) return value_t'($urandom() | 32'h8000_0000);
    if (pick < 70) return value_t'($urandom() & 32'h7fff_fffe);
    if (pick < 90) begin
      p = 2 * $urandom_range(1, 49) + 1;
      q = longint'($urandom_range(1, int'(MAX_POS / p))) | 1;
      if (p * q > MAX_POS) q -= 2;
      return value_t'(p * q);
    end
    return value_t'($urandom_range(4097, 262143));
  endfunction

  // Stimulus
  initial begin
    value_t directed_values[$];
    quiet_phase  = 1'b0;
    hold_reply   = 1'b0;
    queries_sent = 0;
    directed_values = '{
      value_t'(32'h8000_0000), value_t'(-1), value_t'(-7),
      value_t'(0), value_t'(1), value_t'(2), value_t'(3), value_t'(4),
      value_t'(5), value_t'(9), value_t'(15), value_t'(21), value_t'(25),
      value_t'(49), value_t'(97), value_t'(65521), value_t'(65537),
      value_t'(1018081), value_t'(32'h7fff_fffe), value_t'(32'h7fff_fffd),
      value_t'(32'h5555_5555), value_t'(32'h7fff_ffff)
    };

    wait (!rst);
    @(negedge clk);

    // Directed edge values
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      maybe_gap();
    end

    // Pause the sender until every verdict is back
    idle_query(1);
    wait_drained();

    // Long reply hold-off while operands keep coming back to back
    hold_reply = 1'b1;
    repeat (8) send_value(value_t'($urandom_range(0, 200)));

    // Random operands with idling on both sides
    repeat (RANDOM_ITEMS - QUIET_ITEMS) begin
      send_value(random_value());
      maybe_gap();
    end

    // Tail with no idling at all
    quiet_phase = 1'b1;
    repeat (QUIET_ITEMS) send_value(value_t'($urandom_range(0, 4095)));
    idle_query(1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (verdicts.pending() != 0) verdicts.mismatches++;
    $display("Covered %0d queries: sign and range extremes, small and large composites,",
             queries_sent);
    $display("primes up to 2^31-1 (%0d prime of %0d replies), input backpressure, drained pause.",
             verdicts.primes_seen, verdicts.replies_checked);
    if (verdicts.mismatches == 0) begin
      $display("trial_division_prime_test_top test passed");
    end else begin
      $display("trial_division_prime_test_top test failed");
    end
    $finish;
  end

endmodule

// ----- trial_division_prime_test_top.f -----
hdl/tdp_pkg.sv
hdl/tdp_ifs.sv
hdl/tdp_divider.sv
hdl/trial_division_prime_test_top.sv
hdl/tdp_checker.sv
dv/testbench.sv
